// ----- rtl/core/oasd_pkg.sv -----
package oasd_pkg;

  // Step directions, as coded on the result port
  typedef enum logic [1:0] {
    DIR_PX = 2'd0,
    DIR_NX = 2'd1,
    DIR_PY = 2'd2,
    DIR_NY = 2'd3
  } dir_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_EXIT_X     = 3'd0,
    CFG_EXIT_Y     = 3'd1,
    CFG_OBST_COUNT = 3'd2,
    CFG_REACH_X    = 3'd3,
    CFG_REACH_Y    = 3'd4,
    CFG_SIDE_HW    = 3'd5
  } cfg_idx_e;

  localparam logic [14:0] REACH_X_RST = 15'd307;
  localparam logic [14:0] REACH_Y_RST = 15'd118;
  localparam logic [14:0] SIDE_HW_RST = 15'd18;

  // Window geometry shared by every cell
  typedef struct packed {
    logic [14:0] reach_x;
    logic [14:0] reach_y;
    logic [14:0] side_hw;
  } reach_t;

  // Query token that walks down the cell row
  typedef struct packed {
    logic        valid;
    logic [15:0] px;
    logic [15:0] py;
    logic [3:0]  blocked;   // indexed by dir_e
  } tok_t;

  // Priority order per quadrant {dx < 0, dy < 0}, first entry tried first
  localparam logic [1:0] PRIO_TBL [4][4] = '{
    '{DIR_PX, DIR_PY, DIR_NY, DIR_NX},
    '{DIR_PX, DIR_NY, DIR_NX, DIR_PY},
    '{DIR_NX, DIR_PY, DIR_NY, DIR_PX},
    '{DIR_NX, DIR_NY, DIR_PX, DIR_PY}
  };

endpackage

// ----- rtl/core/oasd_cell.sv -----
module oasd_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            wr_i,
  input  logic [15:0]     wr_x_i,
  input  logic [15:0]     wr_y_i,
  input  logic            on_i,
  input  oasd_pkg::reach_t reach_i,
  input  oasd_pkg::tok_t  tok_i,
  output oasd_pkg::tok_t  tok_o
);

  logic [15:0] ox_q;
  logic [15:0] oy_q;
  oasd_pkg::tok_t tok_q;
  oasd_pkg::tok_t tok_d;

  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic [16:0] adx;
  logic [16:0] ady;
  logic x_near;
  logic y_near;
  logic [3:0] hit;

  // Stored obstacle point
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      ox_q <= wr_x_i;
      oy_q <= wr_y_i;
    end
  end

  // Offsets from the pedestrian at full precision
  always_comb begin
    dx  = $signed({ox_q[15], ox_q}) - $signed({tok_i.px[15], tok_i.px});
    dy  = $signed({oy_q[15], oy_q}) - $signed({tok_i.py[15], tok_i.py});
    adx = dx[16] ? 17'(-dx) : 17'(dx);
    ady = dy[16] ? 17'(-dy) : 17'(dy);
  end

  // Window tests, all bounds inclusive
  always_comb begin
    y_near = {ady, 1'b0} <= {3'b000, reach_i.reach_y};
    x_near = adx <= {2'b00, reach_i.side_hw};
    hit = '0;
    hit[oasd_pkg::DIR_PX] = !dx[16] && (adx <= {2'b00, reach_i.reach_x}) && y_near;
    hit[oasd_pkg::DIR_NX] = (dx[16] || (dx == '0)) && (adx <= {2'b00, reach_i.reach_x})
                            && y_near;
    hit[oasd_pkg::DIR_PY] = !dy[16] && (ady <= {2'b00, reach_i.reach_y}) && x_near;
    hit[oasd_pkg::DIR_NY] = (dy[16] || (dy == '0)) && (ady <= {2'b00, reach_i.reach_y})
                            && x_near;
  end

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && on_i) begin
      tok_d.blocked = tok_i.blocked | hit;
    end
  end

  // Hand the token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q.valid <= 1'b0;
    end else if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- rtl/core/oasd_pick.sv -----
module oasd_pick (
  input  oasd_pkg::tok_t tok_i,
  input  logic [15:0]    exit_x_i,
  input  logic [15:0]    exit_y_i,
  output logic [1:0]     direction_o,
  output logic           all_blocked_o
);

  logic signed [16:0] ddx;
  logic signed [16:0] ddy;
  logic [1:0] quad;
  logic [1:0] cand;
  logic found;

  // Quadrant from the sign of the exit offset
  always_comb begin
    ddx  = $signed({exit_x_i[15], exit_x_i}) - $signed({tok_i.px[15], tok_i.px});
    ddy  = $signed({exit_y_i[15], exit_y_i}) - $signed({tok_i.py[15], tok_i.py});
    quad = {ddx[16], ddy[16]};
  end

  // First free direction in priority order
  always_comb begin
    found       = 1'b0;
    cand        = '0;
    direction_o = oasd_pkg::DIR_PX;
    for (int k = 0; k < 4; k++) begin
      cand = oasd_pkg::PRIO_TBL[quad][k];
      if (!found && !tok_i.blocked[cand]) begin
        found       = 1'b1;
        direction_o = cand;
      end
    end
    all_blocked_o = !found;
  end

endmodule

// ----- rtl/core/obstacle_aware_step_direction.sv -----
// Channel   Handshake                     Payload
// in        in_valid_i / in_stall_o       mode_i, entry_index_i, pos_x_i, pos_y_i
// out       out_valid_o / out_stall_i     direction_o, all_blocked_o
// cfg       cfg_we_i                      cfg_idx_i, cfg_wdata_i
//
// A write item is taken at once and does not set busy. A query walks the row of
// MAX_OBSTACLES cells, one cell per cycle unless the row is held, and its result
// is registered at the end of the row as busy clears. The input stalls while a
// query is in the row. A finished query waits at the end of the row while the
// output register is full and stalled. Reset clears control and the exit and count
// registers, loads the reach defaults; table entries are undefined until written.
module obstacle_aware_step_direction #(
  parameter int MAX_OBSTACLES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  entry_index_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  direction_o,
  output logic        all_blocked_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int CW = ($clog2(MAX_OBSTACLES + 1) > 9) ? $clog2(MAX_OBSTACLES + 1) : 9;
  localparam int IW = ($clog2(MAX_OBSTACLES) > 8) ? $clog2(MAX_OBSTACLES) : 8;

  logic [15:0] exit_x_q;
  logic [15:0] exit_y_q;
  logic [8:0]  count_q;
  oasd_pkg::reach_t reach_q;

  logic busy_q;
  logic busy_d;
  logic out_valid_q;
  logic out_valid_d;
  logic [1:0] dir_q;
  logic blk_q;

  logic in_fire;
  logic wr_fire;
  logic qry_fire;
  logic adv;
  logic done;
  logic [1:0] pick_dir;
  logic pick_blk;

  oasd_pkg::tok_t tok_in;
  oasd_pkg::tok_t chain [MAX_OBSTACLES+1];
  logic [MAX_OBSTACLES-1:0] chain_vld;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exit_x_q        <= '0;
      exit_y_q        <= '0;
      count_q         <= '0;
      reach_q.reach_x <= oasd_pkg::REACH_X_RST;
      reach_q.reach_y <= oasd_pkg::REACH_Y_RST;
      reach_q.side_hw <= oasd_pkg::SIDE_HW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        oasd_pkg::CFG_EXIT_X:     exit_x_q        <= cfg_wdata_i;
        oasd_pkg::CFG_EXIT_Y:     exit_y_q        <= cfg_wdata_i;
        oasd_pkg::CFG_OBST_COUNT: count_q         <= cfg_wdata_i[8:0];
        oasd_pkg::CFG_REACH_X:    reach_q.reach_x <= cfg_wdata_i[14:0];
        oasd_pkg::CFG_REACH_Y:    reach_q.reach_y <= cfg_wdata_i[14:0];
        oasd_pkg::CFG_SIDE_HW:    reach_q.side_hw <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // Input transfer and row control
  assign in_stall_o = busy_q;
  assign in_fire    = in_valid_i && !busy_q;
  assign wr_fire    = in_fire && !mode_i;
  assign qry_fire   = in_fire && mode_i;
  assign adv        = !(chain[MAX_OBSTACLES].valid && out_valid_q && out_stall_i);
  assign done       = chain[MAX_OBSTACLES].valid && adv;

  always_comb begin
    tok_in.valid   = qry_fire;
    tok_in.px      = pos_x_i;
    tok_in.py      = pos_y_i;
    tok_in.blocked = '0;
  end

  assign chain[0] = tok_in;

  // Row of obstacle cells
  for (genvar g = 0; g < MAX_OBSTACLES; g++) begin : g_cell
    logic hit_wr;
    logic on;
    assign hit_wr = wr_fire && (IW'(entry_index_i) == IW'(g));
    assign on     = CW'(g) < CW'(count_q);
    assign chain_vld[g] = chain[g+1].valid;

    oasd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .wr_i    (hit_wr),
      .wr_x_i  (pos_x_i),
      .wr_y_i  (pos_y_i),
      .on_i    (on),
      .reach_i (reach_q),
      .tok_i   (chain[g]),
      .tok_o   (chain[g+1])
    );
  end

  oasd_pick u_pick (
    .tok_i         (chain[MAX_OBSTACLES]),
    .exit_x_i      (exit_x_q),
    .exit_y_i      (exit_y_q),
    .direction_o   (pick_dir),
    .all_blocked_o (pick_blk)
  );

  // Busy flag and output register
  always_comb begin
    busy_d = busy_q;
    if (qry_fire) begin
      busy_d = 1'b1;
    end else if (done) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      dir_q <= pick_dir;
      blk_q <= pick_blk;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign direction_o   = dir_q;
  assign all_blocked_o = blk_q;

  // Checks
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(chain_vld) <= 1)
    else $error("more than one query in the cell row");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (chain_vld == '0))
    else $error("token in the row while not busy");

  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q))
    else $error("result without a query in flight");

  a_blocked_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && all_blocked_o) |-> (direction_o == oasd_pkg::DIR_PX))
    else $error("all-blocked result with nonzero direction");

endmodule
